[rtl/core/rgbab_pkg.sv]
package rgbab_pkg;

  typedef enum logic [1:0] {
    MODE_CONVERT = 2'd0,
    MODE_BGRA    = 2'd1,
    MODE_WHITE   = 2'd2,
    MODE_TINT    = 2'd3
  } blend_mode_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_RED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_OPACITY = 3'd4;

  localparam int unsigned WEIGHT_W = 17;
  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 17'd65536;
  localparam logic [12:0] OPACITY_ONE = 13'd4096;

  localparam logic [7:0] WHITE_5 = 8'd31;
  localparam logic [7:0] WHITE_6 = 8'd63;

endpackage

[rtl/core/rgb565_alpha_blend_pixel.sv]
// RGB565 alpha blend pixel engine.
// Input channel: in_valid/in_stall with the source pixel (red, green, blue,
// alpha) and the destination RGB565 word. One word is taken at each edge
// where in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with the new RGB565 word in out_pixel.
// Configuration: cfg_valid/cfg_ready with a register index and data; the
// port is always ready. Registers are blend mode, tint red, green, blue and
// tint opacity. Write them only while no word is in flight.
// A word passes the alpha weight, tint scaling and per-channel multiplier
// stages, then the sum and output register, before out_valid rises.
// The block takes one word per clock while the receiver does not stall;
// each stage holds one word. When the receiver stalls, the output register
// holds its word and a stage freezes only while the stage ahead is full, so
// bubbles are squeezed out and in_stall rises only once the pipeline is full.
// Reset clears all valid bits and returns the registers to convert mode with
// a white, fully opaque tint.
module rgb565_alpha_blend_pixel (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_src_red,
  input  logic [7:0]                       in_src_green,
  input  logic [7:0]                       in_src_blue,
  input  logic [7:0]                       in_src_alpha,
  input  logic [15:0]                      in_back_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [15:0]                      out_pixel,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rgbab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbab_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rgbab_pkg::*;

  // Configuration registers.
  blend_mode_t mode_r;
  logic [7:0]  tint_red_r;
  logic [7:0]  tint_green_r;
  logic [7:0]  tint_blue_r;
  logic [12:0] tint_opacity_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_CONVERT;
      tint_red_r     <= 8'd255;
      tint_green_r   <= 8'd255;
      tint_blue_r    <= 8'd255;
      tint_opacity_r <= OPACITY_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLEND_MODE:   mode_r         <= blend_mode_t'(cfg_data[1:0]);
        REG_TINT_RED:     tint_red_r     <= cfg_data[7:0];
        REG_TINT_GREEN:   tint_green_r   <= cfg_data[7:0];
        REG_TINT_BLUE:    tint_blue_r    <= cfg_data[7:0];
        REG_TINT_OPACITY: tint_opacity_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic en1, en2, en3, en4;

  assign en4      = !out_valid_r || !out_stall;
  assign en3      = !s3_valid_r || en4;
  assign en2      = !s2_valid_r || en3;
  assign en1      = !s1_valid_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) s1_valid_r  <= in_valid;
      if (en2) s2_valid_r  <= s1_valid_r;
      if (en3) s3_valid_r  <= s2_valid_r;
      if (en4) out_valid_r <= s3_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  // Stage 1: alpha weight a*65536/255, which is exactly a*257 plus one at a == 255.
  logic [WEIGHT_W-1:0] s1_weight_nxt, s1_weight_r;
  logic [7:0]          s1_red_r, s1_green_r, s1_blue_r;
  logic [15:0]         s1_back_r;

  assign s1_weight_nxt = WEIGHT_W'({in_src_alpha, in_src_alpha})
                       + WEIGHT_W'(in_src_alpha == 8'hFF);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_weight_r <= s1_weight_nxt;
      s1_red_r    <= in_src_red;
      s1_green_r  <= in_src_green;
      s1_blue_r   <= in_src_blue;
      s1_back_r   <= in_back_pixel;
    end
  end

  // Stage 2: tint opacity scaling, inverse weight and blend colors.
  logic [12:0]         opacity;
  logic [29:0]         tint_prod;
  logic [WEIGHT_W-1:0] weight;
  logic [WEIGHT_W-1:0] w_rb_nxt, w_g_nxt, inv_nxt;
  logic [7:0]          c_red_nxt, c_green_nxt, c_blue_nxt;

  assign opacity   = (tint_opacity_r > OPACITY_ONE) ? OPACITY_ONE : tint_opacity_r;
  assign tint_prod = 30'(s1_weight_r) * 30'(opacity);

  always_comb begin
    weight      = s1_weight_r;
    w_rb_nxt    = s1_weight_r;
    w_g_nxt     = s1_weight_r;
    c_red_nxt   = 8'd0;
    c_green_nxt = 8'd0;
    c_blue_nxt  = 8'd0;
    case (mode_r)
      MODE_BGRA: begin
        // Source colors stay at 8 bits; the weight carries the 565 scaling.
        w_rb_nxt    = s1_weight_r >> 3;
        w_g_nxt     = s1_weight_r >> 2;
        c_red_nxt   = s1_red_r;
        c_green_nxt = s1_green_r;
        c_blue_nxt  = s1_blue_r;
      end
      MODE_WHITE: begin
        c_red_nxt   = WHITE_5;
        c_green_nxt = WHITE_6;
        c_blue_nxt  = WHITE_5;
      end
      MODE_TINT: begin
        weight      = tint_prod[28:12];
        w_rb_nxt    = tint_prod[28:12];
        w_g_nxt     = tint_prod[28:12];
        c_red_nxt   = {3'd0, tint_red_r[7:3]};
        c_green_nxt = {2'd0, tint_green_r[7:2]};
        c_blue_nxt  = {3'd0, tint_blue_r[7:3]};
      end
      default: ;
    endcase
    inv_nxt = FULL_WEIGHT - weight;
  end

  logic [WEIGHT_W-1:0] s2_w_rb_r, s2_w_g_r, s2_inv_r;
  logic [7:0]          s2_c_red_r, s2_c_green_r, s2_c_blue_r;
  logic [4:0]          s2_back_red_r, s2_back_blue_r;
  logic [5:0]          s2_back_green_r;
  logic [15:0]         s2_conv_r;
  logic                s2_convert_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_w_rb_r       <= w_rb_nxt;
      s2_w_g_r        <= w_g_nxt;
      s2_inv_r        <= inv_nxt;
      s2_c_red_r      <= c_red_nxt;
      s2_c_green_r    <= c_green_nxt;
      s2_c_blue_r     <= c_blue_nxt;
      s2_back_red_r   <= s1_back_r[15:11];
      s2_back_green_r <= s1_back_r[10:5];
      s2_back_blue_r  <= s1_back_r[4:0];
      s2_conv_r       <= {s1_red_r[7:3], s1_green_r[7:2], s1_blue_r[7:3]};
      s2_convert_r    <= (mode_r == MODE_CONVERT);
    end
  end

  // Stage 3: background and color products per channel.
  logic [21:0] s3_bk_red_r, s3_bk_blue_r;
  logic [22:0] s3_bk_green_r;
  logic [24:0] s3_tm_red_r, s3_tm_green_r, s3_tm_blue_r;
  logic [15:0] s3_conv_r;
  logic        s3_convert_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_bk_red_r   <= 22'(s2_back_red_r) * 22'(s2_inv_r);
      s3_bk_green_r <= 23'(s2_back_green_r) * 23'(s2_inv_r);
      s3_bk_blue_r  <= 22'(s2_back_blue_r) * 22'(s2_inv_r);
      s3_tm_red_r   <= 25'(s2_c_red_r) * 25'(s2_w_rb_r);
      s3_tm_green_r <= 25'(s2_c_green_r) * 25'(s2_w_g_r);
      s3_tm_blue_r  <= 25'(s2_c_blue_r) * 25'(s2_w_rb_r);
      s3_conv_r     <= s2_conv_r;
      s3_convert_r  <= s2_convert_r;
    end
  end

  // Stage 4: sum, drop the 16 fraction bits and pack.
  logic [25:0] sum_red, sum_green, sum_blue;
  logic [15:0] pixel_nxt, pixel_r;

  assign sum_red   = 26'(s3_bk_red_r) + 26'(s3_tm_red_r);
  assign sum_green = 26'(s3_bk_green_r) + 26'(s3_tm_green_r);
  assign sum_blue  = 26'(s3_bk_blue_r) + 26'(s3_tm_blue_r);

  assign pixel_nxt = s3_convert_r ? s3_conv_r
                   : {sum_red[20:16], sum_green[21:16], sum_blue[20:16]};

  always_ff @(posedge clk) begin
    if (en4) pixel_r <= pixel_nxt;
  end

  assign out_pixel = pixel_r;

endmodule

[sim/rgb565_alpha_blend_pixel_test.sv]
module rgb565_alpha_blend_pixel_test;
  import rgbab_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_MAX  = 10;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_src_red    = '0;
  logic [7:0]            in_src_green  = '0;
  logic [7:0]            in_src_blue   = '0;
  logic [7:0]            in_src_alpha  = '0;
  logic [15:0]           in_back_pixel = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [15:0]           out_pixel;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = REG_BLEND_MODE;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // Shadow copy of the block's registers, updated on each accepted write.
  blend_mode_t mode_reg      = MODE_CONVERT;
  logic [7:0]  tint_red_reg   = 8'd255;
  logic [7:0]  tint_green_reg = 8'd255;
  logic [7:0]  tint_blue_reg  = 8'd255;
  logic [12:0] tint_op_reg    = OPACITY_ONE;

  logic [15:0] pending_pixels[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_request   = 0;
  bit          steady         = 1'b0;

  rgb565_alpha_blend_pixel u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_src_red    (in_src_red),
    .in_src_green  (in_src_green),
    .in_src_blue   (in_src_blue),
    .in_src_alpha  (in_src_alpha),
    .in_back_pixel (in_back_pixel),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned alpha_to_weight(logic [7:0] a);
    return (32'(a) * 32'd65536) / 32'd255;
  endfunction

  function automatic logic [15:0] blend_pixel(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                                              logic [7:0] sa, logic [15:0] back);
    int unsigned br, bg, bb, w, inv, op, tr, tg, tb, r, g, b;
    br = 32'(back[15:11]);
    bg = 32'(back[10:5]);
    bb = 32'(back[4:0]);
    w  = alpha_to_weight(sa);
    case (mode_reg)
      MODE_CONVERT: begin
        r = 32'(sr) >> 3;
        g = 32'(sg) >> 2;
        b = 32'(sb) >> 3;
        return {r[4:0], g[5:0], b[4:0]};
      end
      MODE_BGRA: begin
        // Source channels stay at 8 bits; the weight carries the shift to 565.
        tr = 32'(sr) * (w >> 3);
        tg = 32'(sg) * (w >> 2);
        tb = 32'(sb) * (w >> 3);
      end
      MODE_WHITE: begin
        tr = 32'd31 * w;
        tg = 32'd63 * w;
        tb = 32'd31 * w;
      end
      default: begin
        // Opacity above opaque saturates at opaque.
        op = (tint_op_reg > OPACITY_ONE) ? 32'(OPACITY_ONE) : 32'(tint_op_reg);
        w  = (w * op) >> 12;
        tr = (32'(tint_red_reg) >> 3) * w;
        tg = (32'(tint_green_reg) >> 2) * w;
        tb = (32'(tint_blue_reg) >> 3) * w;
      end
    endcase
    inv = 32'd65536 - w;
    r = ((br * inv + tr) >> 16) & 32'h1F;
    g = ((bg * inv + tg) >> 16) & 32'h3F;
    b = ((bb * inv + tb) >> 16) & 32'h1F;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  // Mostly short gaps, a few long ones, none at all during steady stretches.
  function automatic int unsigned rand_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady) return 0;
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pixel(input logic [7:0] sr, input logic [7:0] sg, input logic [7:0] sb,
                            input logic [7:0] sa, input logic [15:0] back);
    int unsigned gap;
    in_valid      = 1'b1;
    in_src_red    = sr;
    in_src_green  = sg;
    in_src_blue   = sb;
    in_src_alpha  = sa;
    in_back_pixel = back;
    do @(posedge clk); while (in_stall);
    pending_pixels.push_back(blend_pixel(sr, sg, sb, sa, back));
    gap = rand_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random_pixel();
    logic [7:0] a;
    case ($urandom_range(0, 9))
      0: a = 8'd0;
      1: a = 8'd255;
      default: a = 8'($urandom);
    endcase
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom), a, 16'($urandom));
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BLEND_MODE:   mode_reg = blend_mode_t'(data[1:0]);
      REG_TINT_RED:     tint_red_reg = data[7:0];
      REG_TINT_GREEN:   tint_green_reg = data[7:0];
      REG_TINT_BLUE:    tint_blue_reg = data[7:0];
      REG_TINT_OPACITY: tint_op_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_convert_extremes();
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 16'h0000);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
    send_pixel(8'h07, 8'h03, 8'hF8, 8'd0, 16'h1234);
    send_pixel(8'h80, 8'hFC, 8'h7F, 8'd128, 16'hA5A5);
  endtask

  task automatic test_bgra_blend();
    write_reg(REG_BLEND_MODE, CFG_DATA_W'(MODE_BGRA));
    send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 16'h0000);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 16'h0000);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 16'hFFFF);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd1, 16'h07E0);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd254, 16'hF81F);
    send_pixel(8'hC3, 8'h5A, 8'h3C, 8'd128, 16'h8410);
  endtask

  task automatic test_white_blend();
    write_reg(REG_BLEND_MODE, CFG_DATA_W'(MODE_WHITE));
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 16'h1234);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 16'h0000);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd128, 16'hFFFF);
  endtask

  task automatic test_tint_blend();
    write_reg(REG_BLEND_MODE, CFG_DATA_W'(MODE_TINT));
    // Reset tint is opaque white.
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 16'h0000);
    write_reg(REG_TINT_RED, 13'd0);
    write_reg(REG_TINT_GREEN, 13'd0);
    write_reg(REG_TINT_BLUE, 13'd0);
    write_reg(REG_TINT_OPACITY, 13'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
    write_reg(REG_TINT_RED, 13'd255);
    write_reg(REG_TINT_BLUE, 13'd128);
    write_reg(REG_TINT_OPACITY, 13'd8191);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 16'h0000);
    write_reg(REG_TINT_OPACITY, 13'd4097);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd200, 16'h7BEF);
    write_reg(REG_TINT_OPACITY, 13'd2048);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd128, 16'hFFFF);
  endtask

  task automatic test_random_settings();
    logic [12:0] op;
    for (int unsigned p = 0; p < 8; p++) begin
      case ($urandom_range(0, 4))
        0: op = 13'd0;
        1: op = OPACITY_ONE;
        2: op = 13'd8191;
        3: op = 13'd4097;
        default: op = 13'($urandom);
      endcase
      write_reg(REG_BLEND_MODE, CFG_DATA_W'(p % 4));
      if (p == 1) begin
        write_reg(REG_TINT_RED, 13'd0);
        write_reg(REG_TINT_GREEN, 13'd0);
        write_reg(REG_TINT_BLUE, 13'd0);
      end else if (p == 3) begin
        write_reg(REG_TINT_RED, 13'd255);
        write_reg(REG_TINT_GREEN, 13'd255);
        write_reg(REG_TINT_BLUE, 13'd255);
      end else begin
        write_reg(REG_TINT_RED, 13'($urandom_range(0, 255)));
        write_reg(REG_TINT_GREEN, 13'($urandom_range(0, 255)));
        write_reg(REG_TINT_BLUE, 13'($urandom_range(0, 255)));
      end
      write_reg(REG_TINT_OPACITY, op);
      repeat (120) send_random_pixel();
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and push back.
  task automatic test_output_backpressure();
    write_reg(REG_BLEND_MODE, CFG_DATA_W'(MODE_TINT));
    write_reg(REG_TINT_OPACITY, 13'($urandom_range(0, 4096)));
    hold_request = 150;
    steady = 1'b1;
    repeat (40) send_random_pixel();
    steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_steady_stream();
    write_reg(REG_BLEND_MODE, CFG_DATA_W'(MODE_BGRA));
    steady = 1'b1;
    repeat (60) send_random_pixel();
    steady = 1'b0;
    wait_idle();
  endtask

  always @(negedge clk) begin : drive_out_stall
    int unsigned stall_left;
    int unsigned run_left;
    if (hold_request != 0) begin
      out_stall = 1'b1;
      hold_request--;
    end else if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (run_left != 0 || steady) begin
      out_stall = 1'b0;
      if (run_left != 0) run_left--;
    end else begin
      out_stall  = 1'b0;
      stall_left = rand_gap();
      run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin : check_output
    logic [15:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected output word: out_pixel=%h", out_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("out_pixel wrong: expected %h, got %h", want, out_pixel);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    test_convert_extremes();
    test_bgra_blend();
    test_white_blend();
    test_tint_blend();
    test_random_settings();
    test_output_backpressure();
    test_steady_stream();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
